[design/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg
// shared types and constants of the framed packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  localparam logic [7:0] SyncByte    = 8'hAA;
  localparam logic [7:0] LengthLimit = 8'd250;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic RegOwnAddr   = 1'b0;
  localparam logic RegBcastAddr = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DEST    = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK1  = 3'd5,
    PH_CHECK2  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4
  } event_e;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       was_broadcast;
    logic [7:0] sum_first;
    logic [7:0] sum_second;
  } result_t;

endpackage

`default_nettype wire

[design/fpr_frame_fsm.sv]
// ----------------------------------------------------------------------------
// fpr_frame_fsm
// frame state machine: one received byte per advance, running sums and result
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_frame_fsm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      own_addr_i,
  input  wire logic [7:0]      bcast_addr_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            advance_i,
  output fpr_pkg::result_t     result_o
);
  import fpr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] index_q, index_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] sos_q, sos_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] chk_q, chk_d;
  logic       bcast_q, bcast_d;

  logic       own_hit, bcast_hit;
  logic [7:0] base_sum, base_sos, add_sum, add_sos;

  assign own_hit   = (byte_i == own_addr_i);
  assign bcast_hit = (byte_i == bcast_addr_i);

  // sync restarts both sums
  assign base_sum = (phase_q == PH_HUNT) ? 8'd0 : sum_q;
  assign base_sos = (phase_q == PH_HUNT) ? 8'd0 : sos_q;
  assign add_sum  = base_sum + byte_i;
  assign add_sos  = base_sos + add_sum;

  // next state
  always_comb begin
    phase_d = PH_HUNT;
    left_d  = left_q;
    index_d = index_q;
    sum_d   = sum_q;
    sos_d   = sos_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    chk_d   = chk_q;
    bcast_d = bcast_q;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == SyncByte) begin
          phase_d = PH_DEST;
          sum_d   = add_sum;
          sos_d   = add_sos;
          bcast_d = 1'b0;
        end
      end
      PH_DEST: begin
        if (own_hit || bcast_hit) begin
          phase_d = PH_CMD;
          sum_d   = add_sum;
          sos_d   = add_sos;
          bcast_d = !own_hit;
        end
      end
      PH_CMD: begin
        phase_d = PH_LEN;
        cmd_d   = byte_i;
        sum_d   = add_sum;
        sos_d   = add_sos;
      end
      PH_LEN: begin
        if (byte_i < LengthLimit) begin
          phase_d = (byte_i == 8'd0) ? PH_CHECK1 : PH_PAYLOAD;
          len_d   = byte_i;
          left_d  = byte_i;
          index_d = 8'd0;
          sum_d   = add_sum;
          sos_d   = add_sos;
        end
      end
      PH_PAYLOAD: begin
        if (left_q != 8'd0) begin
          phase_d = (left_q == 8'd1) ? PH_CHECK1 : PH_PAYLOAD;
          left_d  = left_q - 8'd1;
          index_d = index_q + 8'd1;
          sum_d   = add_sum;
          sos_d   = add_sos;
        end
      end
      PH_CHECK1: begin
        phase_d = PH_CHECK2;
        chk_d   = byte_i;
      end
      PH_CHECK2: begin
        phase_d = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // result
  always_comb begin
    result_o           = '0;
    result_o.event_res = EV_IDLE;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == SyncByte) begin
          result_o.event_res = EV_HEADER;
        end
      end
      PH_DEST: begin
        if (own_hit || bcast_hit) begin
          result_o.event_res     = EV_HEADER;
          result_o.was_broadcast = !own_hit;
        end
      end
      PH_CMD, PH_CHECK1: begin
        result_o.event_res     = EV_HEADER;
        result_o.was_broadcast = bcast_q;
      end
      PH_LEN: begin
        if (byte_i < LengthLimit) begin
          result_o.event_res     = EV_HEADER;
          result_o.was_broadcast = bcast_q;
        end
      end
      PH_PAYLOAD: begin
        if (left_q != 8'd0) begin
          result_o.event_res     = EV_PAYLOAD;
          result_o.payload_byte  = byte_i;
          result_o.payload_index = index_q;
          result_o.was_broadcast = bcast_q;
        end
      end
      PH_CHECK2: begin
        result_o.event_res     = ((sum_q == chk_q) && (sos_q == byte_i)) ? EV_GOOD : EV_BAD;
        result_o.frame_command = cmd_q;
        result_o.frame_length  = len_q;
        result_o.was_broadcast = bcast_q;
        result_o.sum_first     = sum_q;
        result_o.sum_second    = sos_q;
      end
      default: begin
        result_o.event_res = EV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= 8'd0;
      index_q <= 8'd0;
      sum_q   <= 8'd0;
      sos_q   <= 8'd0;
      cmd_q   <= 8'd0;
      len_q   <= 8'd0;
      chk_q   <= 8'd0;
      bcast_q <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      index_q <= index_d;
      sum_q   <= sum_d;
      sos_q   <= sos_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      bcast_q <= bcast_d;
    end
  end

endmodule

`default_nettype wire

[design/fpr_out_buf.sv]
// ----------------------------------------------------------------------------
// fpr_out_buf
// two-entry result register with skid slot, ready taken from registers only
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire fpr_pkg::result_t  push_data_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output fpr_pkg::result_t       data_o
);
  import fpr_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    head_q, head_d;
  result_t    skid_q, skid_d;
  logic       pop;

  assign room_o  = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;
  assign pop     = valid_o && ready_i;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    skid_d  = skid_q;
    case ({push_i, pop})
      2'b10: begin
        count_d = count_q + 2'd1;
        if (count_q == 2'd0) begin
          head_d = push_data_i;
        end else begin
          skid_d = push_data_i;
        end
      end
      2'b01: begin
        count_d = count_q - 2'd1;
        head_d  = skid_q;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          head_d = push_data_i;
        end else begin
          head_d = skid_q;
          skid_d = push_data_i;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

[design/framed_packet_receiver_unit.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// sync-byte, length-framed packet receiver with running two-byte checksum
// ----------------------------------------------------------------------------
// Takes one received byte per beat and gives exactly one result beat per
// byte. A byte is held in an input register, then the frame state machine
// updates its state and builds the result in the same cycle, written into a
// two-entry output buffer. One byte per cycle is sustained while the output
// buffer has room; a byte passes the input register, then the buffer head.
// The rate is set by the frame state machine's state and checksum update.
`default_nettype none

module framed_packet_receiver_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // rx_byte
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // payload_byte, payload_index, frame_command, frame_length, sum_first, sum_second
  output logic [47:0]                        m_axis_tdata_o,
  output logic [3:0]                         m_axis_tuser_o,  // event_res, was_broadcast
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpr_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [fpr_pkg::ApbDataW-1:0]  pwdata,
  output logic [fpr_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import fpr_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [7:0] own_addr_q;
  logic [7:0] bcast_addr_q;
  logic       room;
  logic       advance;
  logic       cfg_wr;
  result_t    fsm_result;
  result_t    out_result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {24'd0, (paddr[2] == RegBcastAddr) ? bcast_addr_q : own_addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= 8'd0;
      bcast_addr_q <= 8'hFF;
    end else if (cfg_wr) begin
      if (paddr[2] == RegOwnAddr) begin
        own_addr_q <= pwdata[7:0];
      end else begin
        bcast_addr_q <= pwdata[7:0];
      end
    end
  end

  assign advance         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  fpr_frame_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .own_addr_i   (own_addr_q),
    .bcast_addr_i (bcast_addr_q),
    .byte_i       (in_byte_q),
    .advance_i    (advance),
    .result_o     (fsm_result)
  );

  fpr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (fsm_result),
    .room_o      (room),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_result)
  );

  assign m_axis_tdata_o = {out_result.sum_second, out_result.sum_first,
                           out_result.frame_length, out_result.frame_command,
                           out_result.payload_index, out_result.payload_byte};
  assign m_axis_tuser_o = {out_result.was_broadcast, out_result.event_res};

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[2:0] <= EV_BAD))
    else $error("result event code out of range");

  a_payload_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o[2:0] == EV_PAYLOAD))
      |-> (m_axis_tdata_o[15:8] < LengthLimit - 8'd1))
    else $error("payload index beyond frame limit");

  a_end_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((m_axis_tuser_o[2:0] == EV_GOOD) ||
                         (m_axis_tuser_o[2:0] == EV_BAD)))
      |-> (m_axis_tdata_o[15:0] == 16'd0))
    else $error("frame end beat carries payload fields");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the framed packet receiver
// ----------------------------------------------------------------------------
// Feeds received bytes on the input stream with bursts and gaps while the
// output side stalls on a changing pattern. A frame-level predictor in a
// scoreboard class follows every accepted byte and checks each result beat
// field by field. A short directed run covers drops, zero-length frames,
// broadcast frames and checksum errors. Random frames, broken frames and
// line noise then follow under several address settings, including equal
// addresses and extreme values.
module tb_top;
  import fpr_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 6;

  class frame_scoreboard;
    logic [7:0] own_addr;
    logic [7:0] bcast_addr;
    phase_e     phase;
    logic [7:0] left;
    logic [7:0] index;
    logic [7:0] sum1;
    logic [7:0] sum2;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] check1;
    logic       bcast;
    result_t    expected_q[$];
    int         mismatches;
    int         bytes_seen;
    int         ev_count[5];

    function new();
      own_addr   = 8'd0;
      bcast_addr = 8'd255;
      phase      = PH_HUNT;
      left       = '0;
      index      = '0;
      sum1       = '0;
      sum2       = '0;
      cmd        = '0;
      len        = '0;
      check1     = '0;
      bcast      = 1'b0;
      mismatches = 0;
      bytes_seen = 0;
      foreach (ev_count[i]) ev_count[i] = 0;
    endfunction

    function void write_register(logic idx, logic [7:0] value);
      if (idx == RegOwnAddr) own_addr = value;
      else bcast_addr = value;
    endfunction

    function void accumulate(logic [7:0] b);
      sum1 = sum1 + b;
      sum2 = sum2 + sum1;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      result_t r;
      r = '0;
      r.event_res = EV_IDLE;
      if (phase == PH_HUNT && b == SyncByte) begin
        sum1  = '0;
        sum2  = '0;
        bcast = 1'b0;
        accumulate(b);
        phase = PH_DEST;
        r.event_res = EV_HEADER;
      end else if (phase == PH_DEST && (b == own_addr || b == bcast_addr)) begin
        bcast = (b != own_addr);
        accumulate(b);
        phase = PH_CMD;
        r.event_res = EV_HEADER;
      end else if (phase == PH_CMD) begin
        cmd = b;
        accumulate(b);
        phase = PH_LEN;
        r.event_res = EV_HEADER;
      end else if (phase == PH_LEN && b < LengthLimit) begin
        len   = b;
        left  = b;
        index = '0;
        accumulate(b);
        phase = (b == 8'd0) ? PH_CHECK1 : PH_PAYLOAD;
        r.event_res = EV_HEADER;
      end else if (phase == PH_PAYLOAD && left != 8'd0) begin
        accumulate(b);
        r.payload_byte  = b;
        r.payload_index = index;
        index = index + 8'd1;
        left  = left - 8'd1;
        if (left == 8'd0) phase = PH_CHECK1;
        r.event_res = EV_PAYLOAD;
      end else if (phase == PH_CHECK1) begin
        check1 = b;
        phase  = PH_CHECK2;
        r.event_res = EV_HEADER;
      end else if (phase == PH_CHECK2) begin
        r.event_res     = (sum1 == check1 && sum2 == b) ? EV_GOOD : EV_BAD;
        r.frame_command = cmd;
        r.frame_length  = len;
        r.sum_first     = sum1;
        r.sum_second    = sum2;
        phase = PH_HUNT;
      end else begin
        phase = PH_HUNT;
      end
      if (r.event_res != EV_IDLE) r.was_broadcast = bcast;
      ev_count[r.event_res]++;
      bytes_seen++;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_result(logic [47:0] data, logic [3:0] user);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %0h tuser %0h", data, user);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("event_res", 8'(exp.event_res), 8'(user[2:0]));
      compare_field("was_broadcast", 8'(exp.was_broadcast), 8'(user[3]));
      compare_field("payload_byte", exp.payload_byte, data[7:0]);
      compare_field("payload_index", exp.payload_index, data[15:8]);
      compare_field("frame_command", exp.frame_command, data[23:16]);
      compare_field("frame_length", exp.frame_length, data[31:24]);
      compare_field("sum_first", exp.sum_first, data[39:32]);
      compare_field("sum_second", exp.sum_second, data[47:40]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = 8'd0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [47:0]         m_axis_tdata_o;
  logic [3:0]          m_axis_tuser_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  frame_scoreboard sb;
  logic [7:0]      tx_bytes[$];
  int              burst_left = 0;
  int              idle_cycles = 0;
  int              cycle_count = 0;
  int              stall_left = 0;
  int              frames_sent = 0;

  framed_packet_receiver_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side stall pattern, cycling through four modes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 256) % 4)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 2) != 0);
      2: m_axis_tready_i <= ((cycle_count % 5) < 3);
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          m_axis_tready_i <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left <= $urandom_range(1, 8);
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    endcase
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_rx_byte(s_axis_tdata_i);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchdogLimit);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_queued();
    logic [7:0] b;
    int         gap;
    while (tx_bytes.size() != 0) begin
      b = tx_bytes.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= b;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_register(input logic idx, input logic [7:0] value);
    logic [ApbDataW-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[7:0] !== value) begin
      $error("register readback mismatch: expected %0h, actual %0h", value, readback[7:0]);
      sb.mismatches++;
    end
  endtask

  task automatic set_addresses(input logic [7:0] own, input logic [7:0] bcast);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    set_register(RegOwnAddr, own);
    set_register(RegBcastAddr, bcast);
  endtask

  // check_mode 0 good, 1 bad first check byte, 2 bad second check byte
  function automatic void add_frame(logic [7:0] dest, logic [7:0] cmd, logic [7:0] len,
                                    int check_mode);
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] hdr[4];
    logic [7:0] pb;
    hdr = '{SyncByte, dest, cmd, len};
    s1 = '0;
    s2 = '0;
    foreach (hdr[i]) begin
      s1 = s1 + hdr[i];
      s2 = s2 + s1;
      tx_bytes.push_back(hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      pb = ($urandom_range(0, 15) == 0) ? SyncByte : 8'($urandom_range(0, 255));
      s1 = s1 + pb;
      s2 = s2 + s1;
      tx_bytes.push_back(pb);
    end
    if (check_mode == 1) s1 = s1 ^ 8'($urandom_range(1, 255));
    if (check_mode == 2) s2 = s2 ^ 8'($urandom_range(1, 255));
    tx_bytes.push_back(s1);
    tx_bytes.push_back(s2);
    frames_sent++;
  endfunction

  initial begin
    logic [7:0] own_cfg;
    logic [7:0] bcast_cfg;
    logic [7:0] dest;
    logic [7:0] len;
    int         phase_bytes;
    int         pick;
    int         n;

    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: drops, zero length, broadcast with bad checksum, rejected sync
    set_addresses(8'h3C, 8'hC3);
    tx_bytes = '{8'h00, 8'hFF, SyncByte, 8'h55, SyncByte, 8'h3C, 8'hFF, LengthLimit};
    add_frame(8'h3C, 8'h00, 8'd0, 0);
    add_frame(8'hC3, 8'h81, 8'd2, 2);
    tx_bytes.push_back(SyncByte);
    tx_bytes.push_back(SyncByte);
    tx_bytes.push_back(8'h3C);
    send_queued();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin own_cfg = 8'd0;   bcast_cfg = 8'd255; end
        1: begin own_cfg = 8'd255; bcast_cfg = 8'd0;   end
        2: begin own_cfg = 8'($urandom_range(0, 255)); bcast_cfg = own_cfg; end
        3: begin own_cfg = SyncByte; bcast_cfg = 8'($urandom_range(0, 255)); end
        default: begin
          own_cfg   = 8'($urandom_range(0, 255));
          bcast_cfg = 8'($urandom_range(0, 255));
        end
      endcase
      set_addresses(own_cfg, bcast_cfg);
      phase_bytes = 0;
      // one longest frame early on
      if (p == 0) begin
        add_frame(own_cfg, 8'($urandom_range(0, 255)), LengthLimit - 8'd1, 0);
        phase_bytes += tx_bytes.size();
        send_queued();
      end
      while (phase_bytes < 170) begin
        if ($urandom_range(0, 29) == 0) wait_drained();
        pick = $urandom_range(0, 99);
        dest = $urandom_range(0, 1) ? own_cfg : bcast_cfg;
        if (pick < 65) begin
          len = ($urandom_range(0, 99) == 0) ? 8'($urandom_range(240, 249))
                                             : 8'($urandom_range(0, 12));
          add_frame(dest, 8'($urandom_range(0, 255)), len,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
          phase_bytes += tx_bytes.size();
        end else if (pick < 80) begin
          tx_bytes.push_back(SyncByte);
          case ($urandom_range(0, 2))
            0: tx_bytes.push_back(8'($urandom_range(0, 255)));
            1: begin
              tx_bytes.push_back(dest);
              tx_bytes.push_back(8'($urandom_range(0, 255)));
              tx_bytes.push_back(8'($urandom_range(250, 255)));
            end
            default: begin
              tx_bytes.push_back(dest);
              tx_bytes.push_back(8'($urandom_range(0, 255)));
              tx_bytes.push_back(8'($urandom_range(1, 20)));
              n = $urandom_range(0, 6);
              for (int i = 0; i < n; i++) tx_bytes.push_back(8'($urandom_range(0, 255)));
            end
          endcase
          phase_bytes += tx_bytes.size();
        end else begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            tx_bytes.push_back($urandom_range(0, 3) == 0 ? SyncByte
                                                         : 8'($urandom_range(0, 255)));
        end
        send_queued();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d bytes in %0d frames sent under 7 address settings",
             sb.bytes_seen, frames_sent);
    $display("results: %0d drops, %0d header beats, %0d payload beats, %0d good, %0d bad",
             sb.ev_count[EV_IDLE], sb.ev_count[EV_HEADER], sb.ev_count[EV_PAYLOAD],
             sb.ev_count[EV_GOOD], sb.ev_count[EV_BAD]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
